// ----- src/lpg_pkg.sv -----
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared widths, types and request codes for the line pixel generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

  // Coordinate and palette widths
  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned COLOR_BITS = 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS:0]   coord_ext_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  // Request kinds
  typedef enum logic [0:0] {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_e;

endpackage

// ----- src/line_pixel_generator_core.sv -----
// ----------------------------------------------------------------------------
// line_pixel_generator_core
// Exact integer line walker: a start request loads two endpoints and a color,
// each step request emits one pixel with a last marker.
// ----------------------------------------------------------------------------
// Unless stalled, the core takes one request per clock and returns each pixel
// in the cycle after its step request is accepted. A start request loads the
// walker registers and emits nothing; a step request while a line is active
// emits the current pixel and advances the walker; a step while idle is
// dropped. The end point is not drawn, and equal endpoints give a single
// pixel. The walker advance (one add, compare and subtract on the remainder)
// sits in the feedback path of the walker registers, while the pixel result
// register takes the current position straight from them, so the sustained
// rate is one request per cycle while unstalled. in_stall_o rises only while a
// pixel sits in the result register and the consumer stalls it.
module line_pixel_generator_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  // request channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             kind_i,
  input  lpg_pkg::coord_t  x_start_i,
  input  lpg_pkg::coord_t  y_start_i,
  input  lpg_pkg::coord_t  x_end_i,
  input  lpg_pkg::coord_t  y_end_i,
  input  lpg_pkg::color_t  color_i,
  // pixel channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lpg_pkg::coord_t  pixel_x_o,
  output lpg_pkg::coord_t  pixel_y_o,
  output lpg_pkg::color_t  pixel_color_o,
  output logic             last_pixel_o
);
  import lpg_pkg::*;

  // walker state
  logic       active_q,     active_d;
  logic       x_major_q,    x_major_d;
  coord_t     cur_x_q,      cur_x_d;
  coord_t     cur_y_q,      cur_y_d;
  coord_t     steps_q,      steps_d;
  coord_t     major_q,      major_d;
  coord_t     minor_q,      minor_d;
  coord_t     rem_q,        rem_d;
  logic       x_down_q,     x_down_d;
  logic       y_down_q,     y_down_d;
  color_t     color_q,      color_d;

  // result register
  logic       out_valid_q,  out_valid_d;
  coord_t     pix_x_q;
  coord_t     pix_y_q;
  color_t     pix_color_q;
  logic       pix_last_q;

  logic       in_acc;
  logic       out_acc;
  logic       start_req;
  logic       step_fire;
  logic       last_step;

  // start decode
  logic       sx_down, sy_down;
  coord_t     span_x, span_y;
  logic       sx_major;
  coord_t     s_major, s_minor;

  // advance
  logic       minor_down;
  logic       minor_step;
  coord_ext_t rem_up;
  coord_t     rem_wrap;
  coord_t     adv_rem;
  coord_t     adv_x, adv_y;

  // Handshakes: hold requests only while a pixel waits and is stalled
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign start_req  = in_acc && (kind_i == KIND_START);
  assign step_fire  = in_acc && (kind_i == KIND_STEP) && active_q;
  assign last_step  = (steps_q <= coord_t'(1));

  // Decode a new line's spans and directions
  always_comb begin
    sx_down  = x_start_i > x_end_i;
    sy_down  = y_start_i > y_end_i;
    span_x   = sx_down ? (x_start_i - x_end_i) : (x_end_i - x_start_i);
    span_y   = sy_down ? (y_start_i - y_end_i) : (y_end_i - y_start_i);
    sx_major = span_x > span_y;
    s_major  = sx_major ? span_x : span_y;
    s_minor  = sx_major ? span_y : span_x;
  end

  // Advance the remainder accumulator and both coordinates by one pixel
  always_comb begin
    minor_down = x_major_q ? y_down_q : x_down_q;
    rem_up     = {1'b0, rem_q} + {1'b0, minor_q};
    // wraps in between, lands below the major span when the minor steps
    rem_wrap   = rem_q + major_q - minor_q;
    if (minor_down) begin
      minor_step = minor_q > rem_q;
      adv_rem    = minor_step ? rem_wrap : (rem_q - minor_q);
    end else begin
      minor_step = rem_up >= {1'b0, major_q};
      adv_rem    = minor_step ? coord_t'(rem_up - {1'b0, major_q})
                              : rem_up[COORD_BITS-1:0];
    end
    adv_x = cur_x_q;
    adv_y = cur_y_q;
    if (x_major_q || minor_step) begin
      adv_x = x_down_q ? (cur_x_q - coord_t'(1)) : (cur_x_q + coord_t'(1));
    end
    if (!x_major_q || minor_step) begin
      adv_y = y_down_q ? (cur_y_q - coord_t'(1)) : (cur_y_q + coord_t'(1));
    end
  end

  // Walker next state: load on start, advance on step
  always_comb begin
    active_d  = active_q;
    x_major_d = x_major_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    steps_d   = steps_q;
    major_d   = major_q;
    minor_d   = minor_q;
    rem_d     = rem_q;
    x_down_d  = x_down_q;
    y_down_d  = y_down_q;
    color_d   = color_q;
    priority if (start_req) begin
      active_d  = 1'b1;
      x_major_d = sx_major;
      cur_x_d   = x_start_i;
      cur_y_d   = y_start_i;
      steps_d   = (s_major == '0) ? coord_t'(1) : s_major;
      major_d   = s_major;
      minor_d   = s_minor;
      rem_d     = '0;
      x_down_d  = sx_down;
      y_down_d  = sy_down;
      color_d   = color_i;
    end else if (step_fire && last_step) begin
      active_d = 1'b0;
      steps_d  = '0;
    end else if (step_fire) begin
      steps_d = steps_q - coord_t'(1);
      rem_d   = adv_rem;
      cur_x_d = adv_x;
      cur_y_d = adv_y;
    end
  end

  // Result valid: set on an emitted pixel, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (step_fire) begin
      out_valid_d = 1'b1;
    end else if (out_acc) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and walker registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      x_major_q   <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      steps_q     <= '0;
      major_q     <= '0;
      minor_q     <= '0;
      rem_q       <= '0;
      x_down_q    <= 1'b0;
      y_down_q    <= 1'b0;
      color_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      x_major_q   <= x_major_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      steps_q     <= steps_d;
      major_q     <= major_d;
      minor_q     <= minor_d;
      rem_q       <= rem_d;
      x_down_q    <= x_down_d;
      y_down_q    <= y_down_d;
      color_q     <= color_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Pixel payload register
  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      pix_x_q     <= cur_x_q;
      pix_y_q     <= cur_y_q;
      pix_color_q <= color_q;
      pix_last_q  <= last_step;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign pixel_color_o = pix_color_q;
  assign last_pixel_o  = pix_last_q;

`ifndef SYNTHESIS
  // Remainder stays below the major span on an active line
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (rem_q < major_q || major_q == '0))
    else $error("remainder accumulator out of range");

  // Minor span never exceeds the major span
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (minor_q <= major_q))
    else $error("minor span exceeds major span");

  // The final pixel closes the line
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && last_step) |=> (!active_q && out_valid_q && pix_last_q))
    else $error("line still active after its last pixel");

  // An emitted pixel lands in the result register
  a_step_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> out_valid_q)
    else $error("step request produced no pixel");

  // An active line always has at least one step left
  a_steps_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (steps_q != '0))
    else $error("active line with no steps left");
`endif

endmodule

// ----- verif/line_pixel_generator_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pixel_generator_checker
// Watches the request and pixel channels of the line walker and keeps its own
// copy of the walker state. Each accepted step request that hits an active line
// queues the pixel it must produce. Each accepted pixel is compared field by
// field with the oldest queued one.
// ----------------------------------------------------------------------------
module line_pixel_generator_checker
  import lpg_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  // request channel
  input  logic   in_valid_i,
  input  logic   in_stall_i,
  input  logic   kind_i,
  input  coord_t x_start_i,
  input  coord_t y_start_i,
  input  coord_t x_end_i,
  input  coord_t y_end_i,
  input  color_t color_i,
  // pixel channel
  input  logic   out_valid_i,
  input  logic   out_stall_i,
  input  coord_t pixel_x_i,
  input  coord_t pixel_y_i,
  input  color_t pixel_color_i,
  input  logic   last_pixel_i,
  // status
  output int     mismatch_count_o,
  output int     pixels_pending_o
);

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

  // Walker copy, cleared as after reset
  logic       walking    = 1'b0;
  logic       x_major    = 1'b0;
  logic       x_down     = 1'b0;
  logic       y_down     = 1'b0;
  coord_t     cur_x      = '0;
  coord_t     cur_y      = '0;
  coord_t     major_span = '0;
  coord_t     minor_span = '0;
  coord_ext_t steps_left = '0;
  coord_ext_t frac       = '0;
  color_t     line_color = '0;

  pixel_t     expected_pixels[$];
  int         mismatches = 0;

  assign mismatch_count_o = mismatches;

  function automatic coord_t span_between(coord_t a, coord_t b);
    return (a > b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

  function automatic coord_t nudge(coord_t v, logic down);
    return down ? coord_t'(v - 1'b1) : coord_t'(v + 1'b1);
  endfunction

  function void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns  pixel mismatch: %s", $time, what);
  endfunction

  // Load a new line, dropping any line in progress
  function void load_line(coord_t xs, coord_t ys, coord_t xe, coord_t ye, color_t c);
    coord_t ax;
    coord_t ay;
    ax         = span_between(xs, xe);
    ay         = span_between(ys, ye);
    line_color = c;
    cur_x      = xs;
    cur_y      = ys;
    x_down     = (xs > xe);
    y_down     = (ys > ye);
    x_major    = (ax > ay);
    major_span = x_major ? ax : ay;
    minor_span = x_major ? ay : ax;
    frac       = '0;
    steps_left = (major_span == '0) ? coord_ext_t'(1) : coord_ext_t'(major_span);
    walking    = 1'b1;
  endfunction

  // Produce the current pixel, then advance one unit along the major axis
  function pixel_t emit_pixel();
    pixel_t px;
    logic   minor_down;
    logic   minor_step;
    px.x       = cur_x;
    px.y       = cur_y;
    px.color   = line_color;
    px.last    = (steps_left <= 1);
    minor_down = x_major ? y_down : x_down;
    minor_step = 1'b0;
    if (steps_left <= 1) begin
      steps_left = '0;
      walking    = 1'b0;
    end else begin
      steps_left = steps_left - 1'b1;
      // frac holds the exact fractional minor position (a deficit when moving down)
      if (minor_down) begin
        if (coord_ext_t'(minor_span) > frac) begin
          minor_step = 1'b1;
          frac       = frac + coord_ext_t'(major_span) - coord_ext_t'(minor_span);
        end else begin
          frac = frac - coord_ext_t'(minor_span);
        end
      end else begin
        frac = frac + coord_ext_t'(minor_span);
        if (frac >= coord_ext_t'(major_span)) begin
          frac       = frac - coord_ext_t'(major_span);
          minor_step = 1'b1;
        end
      end
      if (x_major) begin
        cur_x = nudge(cur_x, x_down);
        if (minor_step) cur_y = nudge(cur_y, y_down);
      end else begin
        cur_y = nudge(cur_y, y_down);
        if (minor_step) cur_x = nudge(cur_x, x_down);
      end
    end
    return px;
  endfunction

  // Predict on each request, compare on each pixel
  always @(posedge clk_i) begin : watch
    pixel_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        if (kind_e'(kind_i) == KIND_START) begin
          load_line(x_start_i, y_start_i, x_end_i, y_end_i, color_i);
        end else if (walking) begin
          expected_pixels.push_back(emit_pixel());
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          flag_mismatch($sformatf("pixel (%0d,%0d) with none expected",
                                  pixel_x_i, pixel_y_i));
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_x_i !== want.x)
            flag_mismatch($sformatf("pixel_x expected %0d got %0d", want.x, pixel_x_i));
          if (pixel_y_i !== want.y)
            flag_mismatch($sformatf("pixel_y expected %0d got %0d", want.y, pixel_y_i));
          if (pixel_color_i !== want.color)
            flag_mismatch($sformatf("pixel_color expected %0d got %0d",
                                    want.color, pixel_color_i));
          if (last_pixel_i !== want.last)
            flag_mismatch($sformatf("last_pixel expected %0d got %0d",
                                    want.last, last_pixel_i));
        end
      end
    end
    pixels_pending_o <= expected_pixels.size();
  end

endmodule

// ----- verif/line_pixel_generator_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pixel_generator_core_tb
// Drives start and step requests into the line walker: a directed set of
// corner lines, one long stall of the pixel consumer, then random short lines
// with restarts, overruns and stray steps. Random gaps on both channels. The
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module line_pixel_generator_core_tb;
  import lpg_pkg::*;

  localparam int unsigned REQUEST_BUDGET = 1350;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam coord_t      COORD_MAX      = '1;

  logic   clk_i     = 1'b0;
  logic   rst_ni    = 1'b0;
  logic   in_valid  = 1'b0;
  logic   kind      = 1'b0;
  coord_t x_start   = '0;
  coord_t y_start   = '0;
  coord_t x_end     = '0;
  coord_t y_end     = '0;
  color_t color     = '0;
  logic   out_stall = 1'b0;

  logic   in_stall;
  logic   out_valid;
  coord_t pixel_x;
  coord_t pixel_y;
  color_t pixel_color;
  logic   last_pixel;
  int     mismatch_count;
  int     pixels_pending;

  int unsigned requests_sent = 0;
  int unsigned hold_ticket   = 0;
  logic        sender_quiet  = 1'b0;
  int unsigned idle_cycles   = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  line_pixel_generator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (kind),
    .x_start_i     (x_start),
    .y_start_i     (y_start),
    .x_end_i       (x_end),
    .y_end_i       (y_end),
    .color_i       (color),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_color_o (pixel_color),
    .last_pixel_o  (last_pixel)
  );

  line_pixel_generator_checker lpg_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .kind_i           (kind),
    .x_start_i        (x_start),
    .y_start_i        (y_start),
    .x_end_i          (x_end),
    .y_end_i          (y_end),
    .color_i          (color),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .pixel_x_i        (pixel_x),
    .pixel_y_i        (pixel_y),
    .pixel_color_i    (pixel_color),
    .last_pixel_i     (last_pixel),
    .mismatch_count_o (mismatch_count),
    .pixels_pending_o (pixels_pending)
  );

  // Mostly short gaps, a few long ones
  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pick a coordinate within reach of base, mirrored back into range
  function automatic coord_t near_coord(coord_t base, int unsigned reach);
    int d;
    int v;
    d = $urandom_range(0, reach);
    v = $urandom_range(0, 1) ? int'(base) + d : int'(base) - d;
    if (v < 0 || v > int'(COORD_MAX)) v = 2 * int'(base) - v;
    return coord_t'(v);
  endfunction

  // Number of pixels a line yields
  function automatic int unsigned line_pixels(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    int unsigned dx;
    int unsigned dy;
    dx = 32'((xs > xe) ? (xs - xe) : (xe - xs));
    dy = 32'((ys > ye) ? (ys - ye) : (ye - ys));
    if (dx > dy) return dx;
    return (dy == 0) ? 1 : dy;
  endfunction

  task automatic send_request(kind_e k, coord_t xs, coord_t ys, coord_t xe, coord_t ye,
                              color_t c);
    int unsigned gap;
    gap = sender_quiet ? 0 : gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind     <= k;
    x_start  <= xs;
    y_start  <= ys;
    x_end    <= xe;
    y_end    <= ye;
    color    <= c;
    do @(posedge clk_i); while (in_stall);
    requests_sent++;
  endtask

  // Step request; the endpoint fields carry junk the block must ignore
  task automatic send_step();
    send_request(KIND_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), color_t'($urandom));
  endtask

  task automatic draw_line(coord_t xs, coord_t ys, coord_t xe, coord_t ye, color_t c,
                           int unsigned steps);
    send_request(KIND_START, xs, ys, xe, ye, c);
    repeat (steps) send_step();
  endtask

  // Hold requests until every predicted pixel has come out
  task automatic wait_for_pixels();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pixels_pending != 0) @(posedge clk_i);
  endtask

  // Pixel consumer: random stalls, one long hold-off on request
  initial begin : consumer
    int unsigned seen_ticket;
    int unsigned stall_left;
    int unsigned run_left;
    seen_ticket = 0;
    stall_left  = 0;
    run_left    = 0;
    forever begin
      @(posedge clk_i);
      if (hold_ticket != seen_ticket) begin
        seen_ticket = hold_ticket;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (stall_left == 0 && run_left == 0) begin
          stall_left = gap_length();
          run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 6);
        end
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          run_left--;
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    coord_t      xs;
    coord_t      ys;
    coord_t      xe;
    coord_t      ye;
    color_t      c;
    int unsigned roll;
    int unsigned pixels;
    int unsigned steps;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner lines
    send_step();                                          // step with no line loaded
    draw_line('0, '0, '0, '0, 8'h00, 1);                  // equal endpoints at origin
    draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 8'hFF, 2); // then a step past end
    draw_line(10'd0, 10'd0, 10'd3, 10'd1, 8'h5A, 3);      // x major, both axes rising
    draw_line(COORD_MAX, COORD_MAX, 10'd1020, 10'd1021, 8'hA5, 3); // x major, both falling
    draw_line(10'd2, 10'd0, 10'd0, 10'd2, 8'h0F, 2);      // tie goes to y, x falling
    draw_line(10'd0, COORD_MAX, 10'd1, 10'd1020, 8'hF0, 1); // y major falling, cut short
    draw_line(10'd512, 10'd511, 10'd511, 10'd512, 8'h81, 1); // restart while busy
    wait_for_pixels();

    // Long consumer hold-off while requests keep coming
    sender_quiet = 1'b1;
    hold_ticket <= hold_ticket + 1;
    draw_line(10'd0, 10'd0, 10'd90, 10'd37, 8'h3C, 91);
    wait_for_pixels();
    sender_quiet = 1'b0;

    // Random lines: mostly complete short walks, some restarts and noise
    while (requests_sent < REQUEST_BUDGET) begin
      if ($urandom_range(0, 9) == 0) sender_quiet = ~sender_quiet;
      roll = $urandom_range(0, 99);
      xs   = coord_t'($urandom);
      ys   = coord_t'($urandom);
      c    = color_t'($urandom);
      if (roll < 4) begin
        // wide line, abandoned partway
        draw_line(xs, ys, coord_t'($urandom), coord_t'($urandom), c, $urandom_range(0, 40));
      end else if (roll < 6) begin
        // medium line walked to the end
        xe = near_coord(xs, 200);
        ye = near_coord(ys, 200);
        draw_line(xs, ys, xe, ye, c, line_pixels(xs, ys, xe, ye));
      end else if (roll < 12) begin
        send_step();
      end else begin
        xe     = near_coord(xs, ($urandom_range(0, 3) == 0) ? 2 : 16);
        ye     = near_coord(ys, ($urandom_range(0, 3) == 0) ? 2 : 16);
        pixels = line_pixels(xs, ys, xe, ye);
        roll   = $urandom_range(0, 9);
        if (roll == 0)     steps = $urandom_range(0, pixels - 1);
        else if (roll < 3) steps = pixels + $urandom_range(1, 3);
        else               steps = pixels;
        draw_line(xs, ys, xe, ye, c, steps);
      end
      if ($urandom_range(0, 39) == 0) wait_for_pixels();
    end

    // Drain and settle
    wait_for_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
